### rtl/ifgp_pkg.sv
// ----------------------------------------------------------------------------
// ifgp_pkg
// Shared codes for the image fit geometry planner: fit modes, status codes
// and the item kinds that the front end hands to the back end.
// ----------------------------------------------------------------------------
package ifgp_pkg;

  localparam logic [2:0] MODE_STRETCH = 3'd0;
  localparam logic [2:0] MODE_CONTAIN = 3'd1;
  localparam logic [2:0] MODE_COVER   = 3'd2;
  localparam logic [2:0] MODE_NONE    = 3'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_MODE = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  // What the back end has to do with a word
  typedef enum logic [2:0] {
    K_STRETCH  = 3'd0,
    K_CONT_H   = 3'd1,  // contain, scaled place height
    K_CONT_W   = 3'd2,  // contain, scaled place width
    K_COVER_W  = 3'd3,  // cover, scaled crop width
    K_COVER_H  = 3'd4,  // cover, scaled crop height
    K_NONE     = 3'd5,
    K_ERR_ZERO = 3'd6,
    K_ERR_MODE = 3'd7
  } kind_e;

endpackage

### rtl/ifgp_if.sv
// ----------------------------------------------------------------------------
// ifgp channel interfaces
// Request channel (extents, mode, focus) and result channel (status and
// rectangles), valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifgp_in_if #(
  parameter int DIM_BITS        = 16,
  parameter int FOCUS_FRAC_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               mode;
  logic [DIM_BITS-1:0]      src_width;
  logic [DIM_BITS-1:0]      src_height;
  logic [DIM_BITS-1:0]      dst_width;
  logic [DIM_BITS-1:0]      dst_height;
  logic [FOCUS_FRAC_BITS:0] focus_horiz;
  logic [FOCUS_FRAC_BITS:0] focus_vert;

  modport source (output valid, mode, src_width, src_height, dst_width, dst_height,
                  focus_horiz, focus_vert, input ready);
  modport sink (input valid, mode, src_width, src_height, dst_width, dst_height,
                focus_horiz, focus_vert, output ready);
endinterface

interface ifgp_out_if #(
  parameter int DIM_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [DIM_BITS-1:0] crop_x;
  logic [DIM_BITS-1:0] crop_y;
  logic [DIM_BITS-1:0] crop_w;
  logic [DIM_BITS-1:0] crop_h;
  logic [DIM_BITS-1:0] place_x;
  logic [DIM_BITS-1:0] place_y;
  logic [DIM_BITS-1:0] place_w;
  logic [DIM_BITS-1:0] place_h;

  modport source (output valid, status, crop_x, crop_y, crop_w, crop_h,
                  place_x, place_y, place_w, place_h, input ready);
  modport sink (input valid, status, crop_x, crop_y, crop_w, crop_h,
                place_x, place_y, place_w, place_h, output ready);
endinterface

### rtl/ifgp_queue.sv
// ----------------------------------------------------------------------------
// ifgp_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ifgp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o    = (cnt_q != CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  ERR_CNT_RANGE: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  ERR_PTR_GAP: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("empty queue with pointer gap");
  ERR_CNT_STEP: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

### rtl/ifgp_front.sv
// ----------------------------------------------------------------------------
// ifgp_front
// Takes request words, forms both cross products, and classifies each word
// into a kind with the product, divisor and clamped focus the back end needs.
// ----------------------------------------------------------------------------
module ifgp_front #(
  parameter int DIM_BITS        = 16,
  parameter int FOCUS_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ifgp_in_if.sink                      in_i,
  output logic                         push_o,
  input  logic                         queue_ready_i,
  output ifgp_pkg::kind_e              kind_o,
  output logic [DIM_BITS-1:0]          sw_o,
  output logic [DIM_BITS-1:0]          sh_o,
  output logic [DIM_BITS-1:0]          dw_o,
  output logic [DIM_BITS-1:0]          dh_o,
  output logic [FOCUS_FRAC_BITS:0]     fx_o,
  output logic [FOCUS_FRAC_BITS:0]     fy_o,
  output logic [2*DIM_BITS-1:0]        prod_o,
  output logic [DIM_BITS-1:0]          div_o
);
  import ifgp_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int PW = 2 * DIM_BITS;
  localparam int FW = FOCUS_FRAC_BITS + 1;
  localparam logic [FW-1:0] FOCUS_ONE = FW'(1) << FOCUS_FRAC_BITS;

  logic          v_q;
  logic [2:0]    mode_q;
  logic [D-1:0]  sw_q, sh_q, dw_q, dh_q;
  logic [FW-1:0] fx_q, fy_q;
  logic [PW-1:0] pa_q, pb_q;  // sw*dh, dw*sh
  logic          accept, wider, zero;

  assign in_i.ready = !v_q || queue_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_i.ready) begin
      v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_i.mode;
      sw_q   <= in_i.src_width;
      sh_q   <= in_i.src_height;
      dw_q   <= in_i.dst_width;
      dh_q   <= in_i.dst_height;
      fx_q   <= (in_i.focus_horiz > FOCUS_ONE) ? FOCUS_ONE : in_i.focus_horiz;
      fy_q   <= (in_i.focus_vert > FOCUS_ONE) ? FOCUS_ONE : in_i.focus_vert;
      pa_q   <= PW'(in_i.src_width) * PW'(in_i.dst_height);
      pb_q   <= PW'(in_i.dst_width) * PW'(in_i.src_height);
    end
  end

  assign wider = pa_q > pb_q;
  assign zero  = (sw_q == '0) || (sh_q == '0) || (dw_q == '0) || (dh_q == '0);

  always_comb begin
    kind_o = K_STRETCH;
    prod_o = pa_q;
    div_o  = sw_q;
    if (zero) begin
      kind_o = K_ERR_ZERO;
    end else begin
      case (mode_q)
        MODE_STRETCH: kind_o = K_STRETCH;
        MODE_CONTAIN: begin
          if (wider) begin
            kind_o = K_CONT_H;
            prod_o = pb_q;
            div_o  = sw_q;
          end else begin
            kind_o = K_CONT_W;
            prod_o = pa_q;
            div_o  = sh_q;
          end
        end
        MODE_COVER: begin
          if (wider) begin
            kind_o = K_COVER_W;
            prod_o = pb_q;
            div_o  = dh_q;
          end else begin
            kind_o = K_COVER_H;
            prod_o = pa_q;
            div_o  = dw_q;
          end
        end
        MODE_NONE: kind_o = K_NONE;
        default:   kind_o = K_ERR_MODE;
      endcase
    end
  end

  assign sw_o = sw_q;
  assign sh_o = sh_q;
  assign dw_o = dw_q;
  assign dh_o = dh_q;
  assign fx_o = fx_q;
  assign fy_o = fy_q;

  ERR_HOLD: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && !queue_ready_i) |=> v_q) else $error("front word dropped under stall");
  ERR_FOCUS: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (fx_q <= FOCUS_ONE && fy_q <= FOCUS_ONE)) else $error("focus not clamped");
  ERR_DIV: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && (kind_o == K_CONT_H || kind_o == K_CONT_W || kind_o == K_COVER_W ||
             kind_o == K_COVER_H)) |-> (div_o != '0)) else $error("zero divisor");

endmodule

### rtl/ifgp_back.sv
// ----------------------------------------------------------------------------
// ifgp_back
// Pipelined restoring divider (one quotient bit per stage), rounding, range
// check, focus placement multiply, and the result register.
// ----------------------------------------------------------------------------
module ifgp_back #(
  parameter int DIM_BITS        = 16,
  parameter int FOCUS_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         pop_o,
  input  ifgp_pkg::kind_e              kind_i,
  input  logic [DIM_BITS-1:0]          sw_i,
  input  logic [DIM_BITS-1:0]          sh_i,
  input  logic [DIM_BITS-1:0]          dw_i,
  input  logic [DIM_BITS-1:0]          dh_i,
  input  logic [FOCUS_FRAC_BITS:0]     fx_i,
  input  logic [FOCUS_FRAC_BITS:0]     fy_i,
  input  logic [2*DIM_BITS-1:0]        prod_i,
  input  logic [DIM_BITS-1:0]          div_i,
  ifgp_out_if.source                   res_o
);
  import ifgp_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int PW = 2 * DIM_BITS;
  localparam int FF = FOCUS_FRAC_BITS;
  localparam int FW = FOCUS_FRAC_BITS + 1;
  localparam int MW = DIM_BITS + FOCUS_FRAC_BITS + 1;
  localparam int NS = PW;
  localparam logic [MW-1:0] HALF = MW'(1) << (FF - 1);

  typedef struct packed {
    kind_e         kind;
    logic [D-1:0]  sw;
    logic [D-1:0]  sh;
    logic [D-1:0]  dw;
    logic [D-1:0]  dh;
    logic [D-1:0]  dv;
    logic [FW-1:0] fx;
    logic [FW-1:0] fy;
  } info_t;

  logic en;
  assign en    = !res_o.valid || res_o.ready;
  assign pop_o = en;

  info_t head;
  assign head = '{kind: kind_i, sw: sw_i, sh: sh_i, dw: dw_i, dh: dh_i, dv: div_i,
                  fx: fx_i, fy: fy_i};

  // ---------------- divider stages
  logic          dv_v_q   [NS];
  logic [D-1:0]  rem_q    [NS];
  logic [PW-1:0] dnd_q    [NS];
  logic [PW-1:0] quo_q    [NS];
  info_t         dinfo_q  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_div
    logic          v_s;
    logic [D-1:0]  rem_s;
    logic [PW-1:0] dnd_s, quo_s;
    info_t         info_s;
    logic [D:0]    trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_s    = valid_i;
      assign rem_s  = '0;
      assign dnd_s  = prod_i;
      assign quo_s  = '0;
      assign info_s = head;
    end else begin : g_next
      assign v_s    = dv_v_q[i-1];
      assign rem_s  = rem_q[i-1];
      assign dnd_s  = dnd_q[i-1];
      assign quo_s  = quo_q[i-1];
      assign info_s = dinfo_q[i-1];
    end

    assign trial = {rem_s, dnd_s[PW-1]};
    assign ge    = trial >= {1'b0, info_s.dv};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (en) begin
        dv_v_q[i] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i]   <= ge ? D'(trial - {1'b0, info_s.dv}) : trial[D-1:0];
        dnd_q[i]   <= {dnd_s[PW-2:0], 1'b0};
        quo_q[i]   <= {quo_s[PW-2:0], ge};
        dinfo_q[i] <= info_s;
      end
    end
  end

  // ---------------- rounding: half up, minimum 1
  logic          rd_v_q;
  logic [PW-1:0] rd_q, rd_d;
  info_t         rd_info_q;
  logic          up;

  assign up = {rem_q[NS-1], 1'b0} >= {1'b0, dinfo_q[NS-1].dv};

  always_comb begin
    rd_d = quo_q[NS-1] + PW'(up);
    if (rd_d == '0) begin
      rd_d = PW'(1);
    end
  end

  // ---------------- range check and slack selection
  logic          ck_v_q;
  logic          ovf_d, ovf_q;
  logic [D-1:0]  sz_q;
  logic [D-1:0]  slh_d, slv_d, slh_q, slv_q;
  logic [D-1:0]  limit;
  info_t         ck_info_q;

  always_comb begin
    limit = '0;
    slh_d = '0;
    slv_d = '0;
    case (rd_info_q.kind)
      K_CONT_H: begin
        limit = rd_info_q.dh;
        slv_d = rd_info_q.dh - rd_q[D-1:0];
      end
      K_CONT_W: begin
        limit = rd_info_q.dw;
        slh_d = rd_info_q.dw - rd_q[D-1:0];
      end
      K_COVER_W: begin
        limit = rd_info_q.sw;
        slh_d = rd_info_q.sw - rd_q[D-1:0];
      end
      K_COVER_H: begin
        limit = rd_info_q.sh;
        slv_d = rd_info_q.sh - rd_q[D-1:0];
      end
      K_NONE: begin
        slh_d = (rd_info_q.sw > rd_info_q.dw) ? rd_info_q.sw - rd_info_q.dw
                                              : rd_info_q.dw - rd_info_q.sw;
        slv_d = (rd_info_q.sh > rd_info_q.dh) ? rd_info_q.sh - rd_info_q.dh
                                              : rd_info_q.dh - rd_info_q.sh;
      end
      default: begin
        limit = '0;
      end
    endcase
  end

  assign ovf_d = (rd_info_q.kind == K_CONT_H || rd_info_q.kind == K_CONT_W ||
                  rd_info_q.kind == K_COVER_W || rd_info_q.kind == K_COVER_H) &&
                 (rd_q > PW'(limit));

  // ---------------- focus multiply
  logic          mu_v_q;
  logic [MW-1:0] mh_q, mv_q;
  logic [D-1:0]  msz_q, mslh_q, mslv_q;
  logic          movf_q;
  info_t         mu_info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      ck_v_q <= 1'b0;
      mu_v_q <= 1'b0;
    end else if (en) begin
      rd_v_q <= dv_v_q[NS-1];
      ck_v_q <= rd_v_q;
      mu_v_q <= ck_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q      <= rd_d;
      rd_info_q <= dinfo_q[NS-1];
      ovf_q     <= ovf_d;
      sz_q      <= rd_q[D-1:0];
      slh_q     <= slh_d;
      slv_q     <= slv_d;
      ck_info_q <= rd_info_q;
      mh_q      <= MW'(slh_q) * MW'(ck_info_q.fx);
      mv_q      <= MW'(slv_q) * MW'(ck_info_q.fy);
      msz_q     <= sz_q;
      mslh_q    <= slh_q;
      mslv_q    <= slv_q;
      movf_q    <= ovf_q;
      mu_info_q <= ck_info_q;
    end
  end

  // ---------------- result assembly
  logic [D-1:0] off_h, off_v;
  logic [MW-1:0] rh, rv;
  logic [1:0]   st_d;
  logic [D-1:0] cx_d, cy_d, cw_d, ch_d, px_d, py_d, pw_d, ph_d;
  info_t        mi;

  assign mi    = mu_info_q;
  assign rh    = (mh_q + HALF) >> FF;
  assign rv    = (mv_q + HALF) >> FF;
  assign off_h = rh[D-1:0];
  assign off_v = rv[D-1:0];

  always_comb begin
    st_d = ST_OK;
    cx_d = '0;
    cy_d = '0;
    cw_d = mi.sw;
    ch_d = mi.sh;
    px_d = '0;
    py_d = '0;
    pw_d = mi.dw;
    ph_d = mi.dh;
    case (mi.kind)
      K_STRETCH: st_d = ST_OK;
      K_CONT_H: begin
        ph_d = msz_q;
        py_d = off_v;
      end
      K_CONT_W: begin
        pw_d = msz_q;
        px_d = off_h;
      end
      K_COVER_W: begin
        cw_d = msz_q;
        cx_d = off_h;
      end
      K_COVER_H: begin
        ch_d = msz_q;
        cy_d = off_v;
      end
      K_NONE: begin
        cw_d = (mi.sw < mi.dw) ? mi.sw : mi.dw;
        ch_d = (mi.sh < mi.dh) ? mi.sh : mi.dh;
        pw_d = cw_d;
        ph_d = ch_d;
        // spare length sits on whichever side is larger
        if (mi.sw > mi.dw) begin
          cx_d = off_h;
        end else begin
          px_d = off_h;
        end
        if (mi.sh > mi.dh) begin
          cy_d = off_v;
        end else begin
          py_d = off_v;
        end
      end
      K_ERR_ZERO: st_d = ST_ZERO;
      K_ERR_MODE: st_d = ST_MODE;
      default:    st_d = ST_OK;
    endcase
    if (movf_q) begin
      st_d = ST_OVF;
    end
    if (st_d != ST_OK) begin
      cx_d = '0;
      cy_d = '0;
      cw_d = '0;
      ch_d = '0;
      px_d = '0;
      py_d = '0;
      pw_d = '0;
      ph_d = '0;
    end
  end

  logic out_v_q;
  assign res_o.valid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_o.status  <= st_d;
      res_o.crop_x  <= cx_d;
      res_o.crop_y  <= cy_d;
      res_o.crop_w  <= cw_d;
      res_o.crop_h  <= ch_d;
      res_o.place_x <= px_d;
      res_o.place_y <= py_d;
      res_o.place_w <= pw_d;
      res_o.place_h <= ph_d;
    end
  end

  ERR_MIN_ONE: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> (rd_q != '0)) else $error("scaled size below one");
  ERR_OFF_H: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_v_q |-> (off_h <= mslh_q)) else $error("horizontal offset beyond slack");
  ERR_OFF_V: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_v_q |-> (off_v <= mslv_q)) else $error("vertical offset beyond slack");

endmodule

### rtl/image_fit_geometry_planner.sv
// Path: front register, queue, divider (one quotient bit per pipeline stage),
//   then rounding, range check, focus multiply and result registers.
// Throughput: one word per cycle; front and back stall independently through
//   a four-entry queue, and the back pipeline stalls as a whole on res_o.ready.
// Reset: rst_ni clears all valid and queue state asynchronously; no result
//   is presented until a request is accepted.
// ----------------------------------------------------------------------------
// image_fit_geometry_planner
// Computes crop and placement rectangles for stretch, contain, cover and
// unscaled fits of a source extent into a destination extent.
// ----------------------------------------------------------------------------
module image_fit_geometry_planner #(
  parameter int DIM_BITS        = 16,
  parameter int FOCUS_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifgp_in_if.sink    in_i,
  ifgp_out_if.source res_o
);
  import ifgp_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int FW = FOCUS_FRAC_BITS + 1;
  localparam int KW = $bits(kind_e);
  localparam int QW = KW + 5 * D + 2 * FW + 2 * D;
  localparam int QDEPTH = 4;

  logic          push, q_ready, q_valid, pop;
  kind_e         f_kind;
  logic [KW-1:0] b_kind;
  logic [D-1:0]  f_sw, f_sh, f_dw, f_dh, f_div, b_sw, b_sh, b_dw, b_dh, b_div;
  logic [FW-1:0] f_fx, f_fy, b_fx, b_fy;
  logic [2*D-1:0] f_prod, b_prod;
  logic [QW-1:0] q_in, q_out;

  ifgp_front #(.DIM_BITS(DIM_BITS), .FOCUS_FRAC_BITS(FOCUS_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_o(push), .queue_ready_i(q_ready),
    .kind_o(f_kind), .sw_o(f_sw), .sh_o(f_sh), .dw_o(f_dw), .dh_o(f_dh),
    .fx_o(f_fx), .fy_o(f_fy), .prod_o(f_prod), .div_o(f_div)
  );

  assign q_in = {f_kind, f_sw, f_sh, f_dw, f_dh, f_fx, f_fy, f_prod, f_div};

  ifgp_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(q_in), .ready_o(q_ready),
    .valid_o(q_valid), .pop_i(pop), .pop_data_o(q_out)
  );

  assign {b_kind, b_sw, b_sh, b_dw, b_dh, b_fx, b_fy, b_prod, b_div} = q_out;

  ifgp_back #(.DIM_BITS(DIM_BITS), .FOCUS_FRAC_BITS(FOCUS_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .pop_o(pop),
    .kind_i(kind_e'(b_kind)), .sw_i(b_sw), .sh_i(b_sh), .dw_i(b_dw), .dh_i(b_dh),
    .fx_i(b_fx), .fy_i(b_fy), .prod_i(b_prod), .div_i(b_div),
    .res_o
  );

endmodule

### test/tb_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_checker
// Watches the request and result channels of the fit planner, predicts each
// plan from the accepted request and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb_fit_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifgp_in_if.sink    req_i,
  ifgp_out_if.sink   res_i,
  input  logic       req_ready_i,
  input  logic       res_ready_i,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         plan_cnt_o
);
  import ifgp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cx, cy, cw, ch, px, py, pw, ph;
  } plan_t;

  plan_t plan_q[$];
  int    fail_cnt = 0;
  int    plan_cnt = 0;

  // round(a*b/d), half up, at least 1
  function automatic logic [63:0] ratio_round(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d);
    logic [63:0] p, q, r;
    p = a * b;
    q = p / d;
    r = p % d;
    if (r * 2 >= d) q++;
    if (q < 1) q = 1;
    return q;
  endfunction

  function automatic logic [63:0] split_slack(logic [63:0] s, logic [16:0] f);
    if (f == 0) return 0;
    if (f >= 17'h10000) return s;
    return (s * f + 64'h8000) >> 16;
  endfunction

  function automatic plan_t fit_plan(logic [2:0] md, logic [63:0] sw, logic [63:0] sh,
                                     logic [63:0] dw, logic [63:0] dh,
                                     logic [16:0] fx, logic [16:0] fy);
    plan_t r;
    logic [63:0] cx, cy, cw, ch, px, py, pw, ph;
    logic [1:0] st;
    logic wider;
    st = ST_OK;
    cx = 0; cy = 0; cw = sw; ch = sh; px = 0; py = 0; pw = dw; ph = dh;
    if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
      st = ST_ZERO;
    end else begin
      wider = (sw * dh) > (dw * sh);
      case (md)
        MODE_STRETCH: ;
        MODE_CONTAIN: begin
          if (wider) begin
            ph = ratio_round(sh, dw, sw);
            if (ph > dh) st = ST_OVF;
            else py = split_slack(dh - ph, fy);
          end else begin
            pw = ratio_round(sw, dh, sh);
            if (pw > dw) st = ST_OVF;
            else px = split_slack(dw - pw, fx);
          end
        end
        MODE_COVER: begin
          if (wider) begin
            cw = ratio_round(sh, dw, dh);
            if (cw > sw) st = ST_OVF;
            else cx = split_slack(sw - cw, fx);
          end else begin
            ch = ratio_round(sw, dh, dw);
            if (ch > sh) st = ST_OVF;
            else cy = split_slack(sh - ch, fy);
          end
        end
        MODE_NONE: begin
          cw = sw < dw ? sw : dw;
          ch = sh < dh ? sh : dh;
          pw = cw;
          ph = ch;
          cx = split_slack(sw - cw, fx);
          cy = split_slack(sh - ch, fy);
          px = split_slack(dw - pw, fx);
          py = split_slack(dh - ph, fy);
        end
        default: st = ST_MODE;
      endcase
    end
    r.status = st;
    if (st == ST_OK) begin
      r.cx = cx[15:0]; r.cy = cy[15:0]; r.cw = cw[15:0]; r.ch = ch[15:0];
      r.px = px[15:0]; r.py = py[15:0]; r.pw = pw[15:0]; r.ph = ph[15:0];
    end else begin
      {r.cx, r.cy, r.cw, r.ch, r.px, r.py, r.pw, r.ph} = '0;
    end
    return r;
  endfunction

  assign pending_o  = plan_q.size();
  assign fail_cnt_o = fail_cnt;
  assign plan_cnt_o = plan_cnt;

  always @(posedge clk_i) begin
    plan_t got, want;
    if (rst_ni) begin
      if (req_i.valid && req_ready_i)
        plan_q.push_back(fit_plan(req_i.mode, req_i.src_width, req_i.src_height,
                                  req_i.dst_width, req_i.dst_height,
                                  req_i.focus_horiz, req_i.focus_vert));
      if (res_i.valid && res_ready_i) begin
        got = {res_i.status, res_i.crop_x, res_i.crop_y, res_i.crop_w, res_i.crop_h,
               res_i.place_x, res_i.place_y, res_i.place_w, res_i.place_h};
        plan_cnt++;
        if (plan_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result word %h", $time, got);
        end else begin
          want = plan_q.pop_front();
          if (got != want) begin
            fail_cnt++;
            $display("%0t: mismatch exp st=%0d crop=%0d,%0d,%0d,%0d place=%0d,%0d,%0d,%0d",
                     $time, want.status, want.cx, want.cy, want.cw, want.ch,
                     want.px, want.py, want.pw, want.ph);
            $display("%0t:          got st=%0d crop=%0d,%0d,%0d,%0d place=%0d,%0d,%0d,%0d",
                     $time, got.status, got.cx, got.cy, got.cw, got.ch,
                     got.px, got.py, got.pw, got.ph);
          end
        end
      end
    end
  end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random fit requests into the planner with random
// idling and a long result stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ifgp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending, plan_cnt;
  int   send_idle = 30, recv_idle = 66;
  logic hold_start;
  logic hold_done;
  int   hold_cycles;
  int   n_sent = 0;

  ifgp_in_if  #(16, 16) req_if ();
  ifgp_out_if #(16)     res_if ();

  image_fit_geometry_planner i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .res_o (res_if)
  );

  tb_fit_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_i      (res_if),
    .req_ready_i(req_if.ready),
    .res_ready_i(res_if.ready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .plan_cnt_o (plan_cnt)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus one counted long hold once requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_cycles  <= 0;
      hold_done    <= 1'b0;
    end else if (hold_start && !hold_done) begin
      res_if.ready <= 1'b0;
      if (hold_cycles == 299) begin
        hold_done <= 1'b1;
      end
      hold_cycles <= hold_cycles + 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(9))
      0: return 16'hffff;
      1: return 16'($urandom_range(1, 4));
      2: return 16'($urandom_range(8)) == 0 ? 16'd0 : 16'($urandom);
      3, 4: return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [16:0] rand_focus();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'h1ffff;
      3: return 17'h08000;
      4: return 17'($urandom) | 17'h10000;
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_req(logic [2:0] md, logic [15:0] sw, logic [15:0] sh,
                          logic [15:0] dw, logic [15:0] dh,
                          logic [16:0] fx, logic [16:0] fy);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= md;
    req_if.src_width   <= sw;
    req_if.src_height  <= sh;
    req_if.dst_width   <= dw;
    req_if.dst_height  <= dh;
    req_if.focus_horiz <= fx;
    req_if.focus_vert  <= fy;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
  endtask

  initial begin
    int wait_cnt;
    logic [2:0] md;
    hold_start         <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= MODE_STRETCH;
    req_if.src_width   <= '0;
    req_if.src_height  <= '0;
    req_if.dst_width   <= '0;
    req_if.dst_height  <= '0;
    req_if.focus_horiz <= '0;
    req_if.focus_vert  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode, zero extents, extremes, focus ends and above one
    send_req(MODE_STRETCH, 1920, 1080, 640, 480, 17'h08000, 17'h08000);
    send_req(MODE_CONTAIN, 1920, 1080, 640, 480, 17'h08000, 17'h08000);
    send_req(MODE_CONTAIN, 1080, 1920, 640, 480, 17'd0, 17'h10000);
    send_req(MODE_COVER, 1920, 1080, 640, 480, 17'h10000, 17'd0);
    send_req(MODE_COVER, 1080, 1920, 640, 480, 17'h1ffff, 17'h1ffff);
    send_req(MODE_NONE, 1920, 1080, 640, 480, 17'h08000, 17'h04000);
    send_req(MODE_NONE, 100, 50, 640, 480, 17'h1ffff, 17'd1);
    send_req(3'd4, 10, 10, 10, 10, 0, 0);
    send_req(3'd7, 65535, 65535, 65535, 65535, 17'h1ffff, 17'h1ffff);
    send_req(3'd5, 0, 10, 10, 10, 0, 0);
    send_req(MODE_CONTAIN, 10, 0, 10, 10, 0, 0);
    send_req(MODE_COVER, 10, 10, 0, 10, 0, 0);
    send_req(MODE_NONE, 10, 10, 10, 0, 0, 0);
    send_req(MODE_CONTAIN, 65535, 1, 1, 65535, 17'h10000, 17'h10000);
    send_req(MODE_CONTAIN, 1, 65535, 65535, 1, 17'h10000, 17'h10000);
    send_req(MODE_COVER, 65535, 1, 1, 65535, 17'h08000, 17'h08000);
    send_req(MODE_COVER, 1, 65535, 65535, 1, 17'h08000, 17'h08000);
    send_req(MODE_STRETCH, 65535, 65535, 65535, 65535, 17'h1ffff, 17'h1ffff);
    send_req(MODE_CONTAIN, 3, 2, 5, 5, 17'h0ffff, 17'h0ffff);
    send_req(MODE_COVER, 3, 2, 5, 5, 17'h00001, 17'h0ffff);
    send_req(MODE_NONE, 65535, 1, 1, 65535, 17'h0ffff, 17'h0ffff);

    // long result stall: sender keeps offering so the queue backs up
    hold_start <= 1'b1;
    for (int i = 0; i < 1800; i++) begin
      if (i == 600) begin
        send_idle = 66;
        recv_idle = 30;
      end else if (i == 1200) begin
        send_idle = 0;
        recv_idle = 0;
      end
      md = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      send_req(md, rand_dim(), rand_dim(), rand_dim(), rand_dim(),
               rand_focus(), rand_focus());
    end
    req_if.valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (60) @(posedge clk_i);
    $display("Sent %0d fit requests over all modes, zero extents and focus extremes;",
             n_sent);
    $display("checked %0d results under mixed idling and a long result stall.",
             plan_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
